>>> hdl/twr_pkg.sv
`default_nettype none

package twr_pkg;

  // Field widths of the packet event and of the result.
  localparam int unsigned BlockW  = 16;
  localparam int unsigned LengthW = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned BytesW  = 10;

  // Payload bytes in one full data block; write_bytes is sized for it.
  localparam int unsigned BlockBytes = 512;

  // Command codes: which port the packet arrived on.
  localparam logic CmdListen   = 1'b0;
  localparam logic CmdTransfer = 1'b1;

  // Low byte of the write request opcode.
  localparam logic [7:0] OpWrq = 8'd2;

  // Header bytes in front of the payload of a data packet.
  localparam logic [LengthW-1:0] HdrBytes = LengthW'(4);

  typedef logic [AddrW-1:0] addr_t;

  typedef struct packed {
    logic               command;
    logic [7:0]         opcode;
    logic [BlockW-1:0]  block_number;
    logic [LengthW-1:0] packet_length;
    logic               fragmented;
  } item_t;

  typedef struct packed {
    logic [BlockW-1:0] ack_block;
    logic              erase_storage;
    logic              write_valid;
    addr_t             write_address;
    logic [BytesW-1:0] write_bytes;
    logic              transfer_done;
  } result_t;

  // Decision for the item at the head of the pipeline.
  typedef struct packed {
    logic    emit;
    result_t result;
  } decision_t;

endpackage

`default_nettype wire

>>> hdl/twr_stream_if.sv
`default_nettype none

// Valid/ready channel carrying one payload item per handshake.
interface twr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/twr_in_stage.sv
`default_nettype none

// Input register: holds one packet event until the session logic takes it.
module twr_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire twr_pkg::item_t in_item_i,
  output logic               in_ready_o,
  input  wire logic          advance_i,
  output logic               valid_o,
  output twr_pkg::item_t     item_o
);

  logic           valid_q, valid_d;
  twr_pkg::item_t item_q;

  // The register is free when empty or when its item moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = (valid_q && !advance_i) || (in_valid_i && in_ready_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> hdl/twr_session.sv
`default_nettype none

// Session state and the per-item decision: start, block check, write, end.
module twr_session (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire twr_pkg::addr_t  cfg_data_i,
  input  wire logic            step_i,
  input  wire twr_pkg::item_t  item_i,
  output twr_pkg::decision_t   decision_o
);

  localparam logic [twr_pkg::LengthW-1:0] FullLen =
    twr_pkg::LengthW'(twr_pkg::BlockBytes + 4);
  localparam twr_pkg::addr_t BlockStep = twr_pkg::AddrW'(twr_pkg::BlockBytes);

  logic                          active_q, active_d;
  logic [twr_pkg::BlockW-1:0]    last_q, last_d;
  twr_pkg::addr_t                ptr_q, ptr_d;
  twr_pkg::addr_t                start_q;

  logic [twr_pkg::LengthW-1:0]   len_sat;
  logic [twr_pkg::BlockW-1:0]    next_blk;
  logic [twr_pkg::BlockW-1:0]    ack_blk;
  logic                          match;
  logic                          do_write;
  logic                          short_pkt;
  twr_pkg::decision_t            dec;

  // Oversized packets count as full ones.
  assign len_sat   = (item_i.packet_length > FullLen) ? FullLen : item_i.packet_length;
  assign next_blk  = last_q + twr_pkg::BlockW'(1);
  assign match     = (item_i.block_number == next_blk);
  assign ack_blk   = match ? item_i.block_number : last_q;
  assign do_write  = match && (len_sat > twr_pkg::HdrBytes);
  assign short_pkt = (len_sat < FullLen);

  // Decide on a result and the next session state.
  always_comb begin
    dec      = '0;
    active_d = active_q;
    last_d   = last_q;
    ptr_d    = ptr_q;
    if (item_i.command == twr_pkg::CmdListen) begin
      if (item_i.opcode == twr_pkg::OpWrq) begin
        dec.emit                 = 1'b1;
        dec.result.erase_storage = 1'b1;
        active_d                 = 1'b1;
        last_d                   = '0;
        ptr_d                    = start_q;
      end
    end else if (active_q && !item_i.fragmented) begin
      dec.emit             = 1'b1;
      dec.result.ack_block = ack_blk;
      last_d               = ack_blk;
      if (do_write) begin
        dec.result.write_valid   = 1'b1;
        dec.result.write_address = ptr_q;
        dec.result.write_bytes   = twr_pkg::BytesW'(len_sat - twr_pkg::HdrBytes);
        ptr_d                    = ptr_q + BlockStep;
      end
      if (short_pkt) begin
        dec.result.transfer_done = 1'b1;
        active_d                 = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      last_q   <= '0;
      ptr_q    <= '0;
      start_q  <= '0;
    end else begin
      if (step_i) begin
        active_q <= active_d;
        last_q   <= last_d;
        ptr_q    <= ptr_d;
      end
      if (cfg_we_i) begin
        start_q <= cfg_data_i;
      end
    end
  end

  assign decision_o = dec;

endmodule

`default_nettype wire

>>> hdl/twr_out_stage.sv
`default_nettype none

// Result register: holds one result until the sink takes it.
module twr_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire twr_pkg::result_t result_i,
  output logic                  can_load_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output twr_pkg::result_t      out_result_o
);

  logic             valid_q, valid_d;
  twr_pkg::result_t result_q;

  // A new result may enter when the register is empty or is being emptied.
  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

`default_nettype wire

>>> hdl/tftp_write_receiver.sv
`default_nettype none

// Channel   Dir  Payload               Meaning
// item_i    in   twr_pkg::item_t       packet event (port, opcode, block, length, fragment)
// result_o  out  twr_pkg::result_t     ack, erase request, block write, end of transfer
// cfg_i     in   32-bit address        upload start address
//
// One item per cycle when results do not stall: an item waits in the input register,
// and its session decision and state update happen as it moves into the result register.
// Items that cause no result only update state and leave no result behind.
// Reset clears the session, block counter, write pointer and start address.
// A stalled result register holds the input register, which then stalls the input.
module tftp_write_receiver (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  twr_stream_if.sink   item_i,
  twr_stream_if.source result_o,
  twr_stream_if.sink   cfg_i
);

  logic               head_valid;
  twr_pkg::item_t     head_item;
  logic               out_can_load;
  logic               advance;
  twr_pkg::decision_t decision;

  // The head item moves on when the result register can take its result.
  assign advance = head_valid && out_can_load;

  assign cfg_i.ready = 1'b1;

  twr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_item_i  (item_i.payload),
    .in_ready_o (item_i.ready),
    .advance_i  (advance),
    .valid_o    (head_valid),
    .item_o     (head_item)
  );

  twr_session u_session (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (twr_pkg::AddrW'(cfg_i.payload)),
    .step_i     (advance),
    .item_i     (head_item),
    .decision_o (decision)
  );

  twr_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && decision.emit),
    .result_i     (decision.result),
    .can_load_o   (out_can_load),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_result_o (result_o.payload)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned BlockBytes = twr_pkg::BlockBytes;
  localparam logic [twr_pkg::LengthW-1:0] FullLength =
    twr_pkg::LengthW'(BlockBytes) + twr_pkg::HdrBytes;

  typedef enum logic [1:0] {RxFree, RxRandom, RxPattern} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  twr_stream_if #(.payload_t(twr_pkg::item_t))   item_if ();
  twr_stream_if #(.payload_t(twr_pkg::result_t)) result_if ();
  twr_stream_if #(.payload_t(twr_pkg::addr_t))   cfg_if ();

  tftp_write_receiver DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // Packet events waiting to be offered, and the replies still owed by the block.
  twr_pkg::item_t   tx_items[$];
  twr_pkg::result_t replies_due[$];

  // Shadow copy of the session state and of the start address register.
  twr_pkg::addr_t             start_addr;
  logic                       sess_active;
  logic [twr_pkg::BlockW-1:0] cur_block;
  twr_pkg::addr_t             wr_ptr;
  logic [31:0]                bytes_rcvd;

  int unsigned mismatches;
  int unsigned items_taken;
  int unsigned replies_seen;
  int unsigned sessions_started;
  int unsigned block_writes;
  int unsigned addr_settings;

  // Handshake bookkeeping shared between the clocked processes.
  bit          item_taken;
  bit          steady_tx;
  int unsigned burst_left;
  int unsigned gap_left;
  rx_mode_e    rx_mode;
  int unsigned rx_tick;
  int unsigned hold_left;
  bit          held_once;

  // Works out the reply, if any, that a packet event causes and updates the session.
  task automatic follow_packet(input twr_pkg::item_t pkt);
    twr_pkg::result_t            reply;
    logic [twr_pkg::LengthW-1:0] len;
    logic [twr_pkg::BlockW-1:0]  next_block;
    bit                          emit;
    reply = '0;
    emit  = 1'b0;
    if (pkt.command == twr_pkg::CmdListen) begin
      if (pkt.opcode == twr_pkg::OpWrq) begin
        sess_active         = 1'b1;
        cur_block           = '0;
        bytes_rcvd          = '0;
        wr_ptr              = start_addr;
        reply.erase_storage = 1'b1;
        emit                = 1'b1;
        sessions_started++;
      end
    end else if (sess_active && !pkt.fragmented) begin
      len        = (pkt.packet_length > FullLength) ? FullLength : pkt.packet_length;
      next_block = cur_block + 1'b1;
      if (pkt.block_number == next_block) begin
        cur_block = next_block;
        if (len > twr_pkg::HdrBytes) begin
          reply.write_valid   = 1'b1;
          reply.write_address = wr_ptr;
          reply.write_bytes   = twr_pkg::BytesW'(len - twr_pkg::HdrBytes);
          bytes_rcvd          = bytes_rcvd + 32'(len - twr_pkg::HdrBytes);
          wr_ptr              = wr_ptr + twr_pkg::AddrW'(BlockBytes);
        end
      end
      // A short packet closes the session, whether or not its block matched.
      if (len < FullLength) begin
        reply.transfer_done = 1'b1;
        sess_active         = 1'b0;
      end
      reply.ack_block = cur_block;
      emit            = 1'b1;
    end
    if (emit) begin
      replies_due.push_back(reply);
    end
  endtask

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Sender: offers queued items in bursts of random length with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
    end else if (!(item_if.valid && !item_taken)) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        item_if.valid <= 1'b0;
      end else if (tx_items.size() > 0) begin
        item_if.valid   <= 1'b1;
        item_if.payload <= tx_items.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = (steady_tx || $urandom_range(0, 1)) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on its own pattern, with one long hold-off to back up the input.
  always @(negedge clk_i) begin
    rx_tick++;
    if (!held_once && replies_seen >= 150) begin
      held_once = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RxFree:   result_if.ready <= 1'b1;
        RxRandom: result_if.ready <= ($urandom_range(0, 9) < 7);
        default:  result_if.ready <= (rx_tick % 5 != 0) && (rx_tick % 13 > 2);
      endcase
    end
  end

  // Monitor: checks each reply against the oldest one owed, then predicts new ones.
  always @(posedge clk_i) begin
    twr_pkg::result_t want;
    twr_pkg::result_t got;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        replies_seen++;
        got = result_if.payload;
        if (replies_due.size() == 0) begin
          $error("reply with none owed: ack_block 0x%0h", got.ack_block);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("ack_block", 32'(want.ack_block), 32'(got.ack_block));
          check_field("erase_storage", 32'(want.erase_storage), 32'(got.erase_storage));
          check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
          check_field("write_address", want.write_address, got.write_address);
          check_field("write_bytes", 32'(want.write_bytes), 32'(got.write_bytes));
          check_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
          if (want.write_valid) begin
            block_writes++;
          end
        end
      end
      if (item_if.valid && item_if.ready) begin
        item_taken = 1'b1;
        items_taken++;
        follow_packet(item_if.payload);
      end
    end
  end

  function automatic twr_pkg::item_t make_pkt(input logic cmd, input logic [7:0] op,
                                              input logic [twr_pkg::BlockW-1:0] blk,
                                              input logic [twr_pkg::LengthW-1:0] len,
                                              input logic frag);
    twr_pkg::item_t pkt;
    pkt.command       = cmd;
    pkt.opcode        = op;
    pkt.block_number  = blk;
    pkt.packet_length = len;
    pkt.fragmented    = frag;
    return pkt;
  endfunction

  function automatic twr_pkg::item_t noise_pkt();
    return make_pkt(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [twr_pkg::LengthW-1:0] full_len();
    return ($urandom_range(0, 2) != 0) ? FullLength
                                       : twr_pkg::LengthW'($urandom_range(FullLength + 1,
                                                                          65535));
  endfunction

  // Queues a write request followed by a mostly well-formed run of data packets.
  task automatic queue_session(input int unsigned blocks);
    logic [twr_pkg::BlockW-1:0]  nb;
    logic [twr_pkg::LengthW-1:0] len;
    int unsigned                 pick;
    nb = twr_pkg::BlockW'(1);
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq,
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
    for (int unsigned k = 0; k < blocks; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'($urandom_range(0, 255)), nb,
                                    16'($urandom_range(0, 65535)), 1'b1));
      end else if (pick < 12) begin
        tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 65535)), full_len(), 1'b0));
      end else if (pick < 15) begin
        tx_items.push_back(make_pkt(twr_pkg::CmdListen,
                                    twr_pkg::OpWrq ^ 8'($urandom_range(1, 255)),
                                    16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)),
                                    1'($urandom_range(0, 1))));
      end else begin
        tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'($urandom_range(0, 255)), nb,
                                    full_len(), 1'b0));
        nb++;
      end
    end
    // Close with a short packet most of the time; otherwise the next request restarts.
    pick = $urandom_range(0, 9);
    if (pick != 0) begin
      len = ($urandom_range(0, 3) == 0)
              ? twr_pkg::LengthW'($urandom_range(0, twr_pkg::HdrBytes))
              : twr_pkg::LengthW'($urandom_range(0, FullLength - 1));
      tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'($urandom_range(0, 255)),
                                  pick == 1 ? 16'($urandom_range(0, 65535)) : nb, len,
                                  1'b0));
    end
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned goal;
    goal = tx_items.size() + count;
    while (tx_items.size() < goal) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) tx_items.push_back(noise_pkt());
      end else begin
        queue_session($urandom_range(0, 14));
      end
    end
  endtask

  // Waits until every item is taken and every reply has come, then lets the pipe drain.
  task automatic settle();
    while (tx_items.size() != 0 || item_if.valid || replies_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start_addr(input twr_pkg::addr_t addr);
    @(negedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= addr;
    do @(posedge clk_i); while (!cfg_if.ready);
    start_addr = addr;
    addr_settings++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Stimulus: directed cases, three random phases, then one steady session that wraps
  // the write pointer.
  initial begin
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    start_addr      = '0;
    sess_active     = 1'b0;
    cur_block       = '0;
    wr_ptr          = '0;
    bytes_rcvd      = '0;
    rx_mode         = RxPattern;
    steady_tx       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_start_addr(32'h0000_0000);
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h00, 16'd1, FullLength, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, 8'h00, 16'd0, 16'd0, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, 8'hFD, 16'hFFFF, 16'hFFFF, 1'b1));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'd0, 16'd0, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd1, FullLength, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'hFF, 16'd2, 16'hFFFF, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd3, 16'd100, 1'b1));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'hFFFF, FullLength, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd3, 16'd5, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd4, FullLength, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'd7, 16'd9, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd1, FullLength, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'd0, 16'd0, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd1, twr_pkg::HdrBytes,
                                1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'd0, 16'd0, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd2, 16'd0, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'd0, 16'd0, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd1, FullLength + 1'b1,
                                1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd2, FullLength - 1'b1,
                                1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'hFFFF, 16'hFFFF,
                                1'b1));
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd1, 16'd3, 1'b0));
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, 8'h82, 16'd0, 16'd0, 1'b0));
    settle();

    write_start_addr(32'hFFFF_FFFF);
    rx_mode = RxRandom;
    queue_random(270);
    settle();

    write_start_addr(twr_pkg::addr_t'($urandom()));
    rx_mode = RxPattern;
    queue_random(270);
    settle();

    write_start_addr(32'hFFFF_FE00);
    rx_mode = RxFree;
    queue_random(270);
    settle();

    // One session of full blocks, offered without gaps, that wraps the write pointer.
    write_start_addr(32'hFFFF_F000);
    steady_tx = 1'b1;
    tx_items.push_back(make_pkt(twr_pkg::CmdListen, twr_pkg::OpWrq, 16'd0, 16'd0, 1'b0));
    for (int unsigned k = 1; k <= 40; k++) begin
      tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'(k), full_len(), 1'b0));
    end
    tx_items.push_back(make_pkt(twr_pkg::CmdTransfer, 8'h03, 16'd2, 16'd300, 1'b0));
    settle();

    $display("Run covered %0d packet events, %0d replies, %0d block writes.",
             items_taken, replies_seen, block_writes);
    $display("Sessions started: %0d, start address settings: %0d, mismatches: %0d.",
             sessions_started, addr_settings, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("Timeout: %0d replies still owed.", replies_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
